// File: hw/rtl/srta_pkg.sv
// ----------------------------------------------------------------------------
// srta_pkg
// Types and constants used by the radix converter's controller and
// datapath, and the byte-wide division step used by the datapath.
// ----------------------------------------------------------------------------
package srta_pkg;

  localparam logic [1:0]  CFG_RADIX      = 2'd0;
  localparam logic [1:0]  CFG_CHARS_LOW  = 2'd1;
  localparam logic [1:0]  CFG_CHARS_HIGH = 2'd2;

  localparam logic [4:0]  RADIX_RESET      = 5'd10;
  localparam logic [4:0]  RADIX_MIN        = 5'd2;
  localparam logic [4:0]  RADIX_MAX        = 5'd16;
  localparam logic [63:0] CHARS_LOW_RESET  = 64'h3736353433323130;
  localparam logic [63:0] CHARS_HIGH_RESET = 64'h6665646362613938;
  localparam logic [7:0]  MINUS_CHAR       = 8'h2d;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_HI,
    ST_DIV_LO,
    ST_SIGN,
    ST_EMIT
  } srta_state_t;

  typedef struct packed {
    logic load;
    logic div_hi;
    logic div_lo;
    logic emit_sign;
    logic emit_digit;
  } srta_cmd_t;

  typedef struct packed {
    logic quo_zero;
    logic neg;
    logic last_digit;
  } srta_status_t;

  typedef struct packed {
    logic [3:0] rem;
    logic [7:0] quo;
  } div_step_t;

  // eight restoring-division steps of one byte by a radix of 2..16
  function automatic div_step_t div_byte(input logic [3:0] rem_in,
                                         input logic [7:0] dividend,
                                         input logic [4:0] radix);
    div_step_t  res;
    logic [4:0] part;
    logic [3:0] rem;
    rem = rem_in;
    res.quo = 8'd0;
    for (int i = 7; i >= 0; i--) begin
      part = {rem, dividend[i]};
      if (part >= radix) begin
        part = part - radix;
        res.quo[i] = 1'b1;
      end
      rem = part[3:0];
    end
    res.rem = rem;
    return res;
  endfunction

endpackage

// File: hw/rtl/srta_ctrl.sv
// ----------------------------------------------------------------------------
// srta_ctrl
// Sequencer: load, divide a byte per cycle until the quotient is zero, then
// send the sign and the stacked digits.
// ----------------------------------------------------------------------------
module srta_ctrl import srta_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  srta_status_t status,
  output srta_cmd_t    cmd,
  output logic         busy
);

  srta_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV_HI;
        end
      end
      ST_DIV_HI: begin
        cmd.div_hi = 1'b1;
        state_nxt  = ST_DIV_LO;
      end
      ST_DIV_LO: begin
        cmd.div_lo = 1'b1;
        if (status.quo_zero) begin
          state_nxt = status.neg ? ST_SIGN : ST_EMIT;
        end else begin
          state_nxt = ST_DIV_HI;
        end
      end
      ST_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit_digit = 1'b1;
        if (status.last_digit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/srta_datapath.sv
// ----------------------------------------------------------------------------
// srta_datapath
// Configuration registers, magnitude and remainder registers, digit stack
// and the registered result beat.
// ----------------------------------------------------------------------------
module srta_datapath import srta_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic [15:0]  in_value_bits,
  input  logic         in_is_signed,
  input  srta_cmd_t    cmd,
  output srta_status_t status,
  output logic         out_valid,
  output logic [7:0]   out_char,
  output logic [4:0]   out_char_count,
  output logic         out_last_char
);

  logic [4:0]   radix_r;
  logic [63:0]  chars_low_r;
  logic [63:0]  chars_high_r;
  logic [15:0]  work_r;
  logic [3:0]   rem_r;
  logic         neg_r;
  logic [4:0]   held_r;
  logic [4:0]   count_r;
  logic [3:0]   stack_r [16];
  logic         out_valid_r;
  logic [7:0]   out_char_r;
  logic [4:0]   out_count_r;
  logic         out_last_r;

  logic [4:0]   radix_eff;
  logic         neg_in;
  div_step_t    step;
  logic [15:0]  quo_full;
  logic [4:0]   held_m1;
  logic [3:0]   digit;
  logic [127:0] chars_all;

  always_comb begin
    if (radix_r < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix_r;
    end
  end

  assign neg_in    = in_is_signed & in_value_bits[15];
  assign step      = div_byte(cmd.div_lo ? rem_r : 4'd0, work_r[15:8], radix_eff);
  assign quo_full  = {work_r[7:0], step.quo};
  assign held_m1   = held_r - 5'd1;
  assign digit     = stack_r[held_m1[3:0]];
  assign chars_all = {chars_high_r, chars_low_r};

  assign status.quo_zero   = (quo_full == 16'd0);
  assign status.neg        = neg_r;
  assign status.last_digit = (held_r == 5'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r      <= RADIX_RESET;
      chars_low_r  <= CHARS_LOW_RESET;
      chars_high_r <= CHARS_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIX:      radix_r      <= cfg_data[4:0];
        CFG_CHARS_LOW:  chars_low_r  <= cfg_data;
        CFG_CHARS_HIGH: chars_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_sign | cmd.emit_digit;
      if (cmd.load) begin
        held_r <= 5'd0;
      end else if (cmd.div_lo) begin
        held_r <= held_r + 5'd1;
      end else if (cmd.emit_digit) begin
        held_r <= held_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r  <= neg_in;
      work_r <= neg_in ? (16'd0 - in_value_bits) : in_value_bits;
    end else if (cmd.div_hi) begin
      work_r <= quo_full;
      rem_r  <= step.rem;
    end else if (cmd.div_lo) begin
      work_r                <= quo_full;
      stack_r[held_r[3:0]]  <= step.rem;
      count_r               <= held_r + 5'd1 + {4'd0, neg_r};
    end
    if (cmd.emit_sign) begin
      out_char_r  <= MINUS_CHAR;
      out_count_r <= count_r;
      out_last_r  <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r  <= chars_all[{digit, 3'b000} +: 8];
      out_count_r <= count_r;
      out_last_r  <= (held_r == 5'd1);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_char_count = out_count_r;
  assign out_last_char  = out_last_r;

endmodule

// File: hw/rtl/short_int_radix_to_ascii.sv
// ----------------------------------------------------------------------------
// short_int_radix_to_ascii
// Converts a 16-bit value, signed or unsigned, to ASCII digits in radix
// 2..16, most significant first, with a leading '-' for negative values.
//
//   channel  handshake           payload
//   input    start / busy        in_value_bits, in_is_signed
//   result   out_valid (strobe)  out_char, out_char_count, out_last_char
//   config   cfg_we              cfg_index, cfg_data
//
// Each digit takes a high-byte and a low-byte step in the byte-serial divider
// and is then sent as one character; a negative value adds a '-' first.
// busy is high from acceptance until the last beat is issued.
// Reset (rst_n low, synchronous) restores radix 10 and table "0..9a..f".
// Result beats last one cycle each; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module short_int_radix_to_ascii import srta_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_value_bits,
  input  logic        in_is_signed,
  output logic        out_valid,
  output logic [7:0]  out_char,
  output logic [4:0]  out_char_count,
  output logic        out_last_char,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  srta_cmd_t    cmd;
  srta_status_t status;

  srta_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  srta_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_value_bits  (in_value_bits),
    .in_is_signed   (in_is_signed),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_char       (out_char),
    .out_char_count (out_char_count),
    .out_last_char  (out_last_char)
  );

endmodule
